@@ sv/crc16_packet_deframer_defines.svh @@
// assertion macros used by the port checker file
`ifndef CRC16_PACKET_DEFRAMER_DEFINES_SVH
`define CRC16_PACKET_DEFRAMER_DEFINES_SVH

// clocked check, muted while reset is high
`define CRCDF_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// clocked check that also holds across reset
`define CRCDF_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/crcdf_pkg.sv @@
package crcdf_pkg;

   localparam logic [7:0]  START_BYTE       = 8'hA1;
   localparam logic [15:0] CRC_INIT         = 16'hFFFF;
   localparam logic [7:0]  MAX_LENGTH_RESET = 8'd200;

   localparam int QUEUE_DEPTH = 4;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   localparam logic [1:0] KIND_PAYLOAD = 2'd0;
   localparam logic [1:0] KIND_ACCEPT  = 2'd1;
   localparam logic [1:0] KIND_REJECT  = 2'd2;

   typedef enum logic [2:0] {
      ST_HUNT  = 3'd0,
      ST_TYPE  = 3'd1,
      ST_LEN   = 3'd2,
      ST_CRCLO = 3'd3,
      ST_CRCHI = 3'd4,
      ST_DATA  = 3'd5
   } parse_state_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] packet_type;
      logic [7:0] payload_length;
      logic [7:0] byte_index;
      logic [7:0] data_byte;
      logic       last;
   } result_type;

   // results produced by one accepted beat, in order
   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } push_type;

   // reflected crc-16, mcrf4xx byte update
   function automatic logic [15:0] crc_step(input logic [7:0] data, input logic [15:0] crc);
      logic [7:0] b;
      b = data ^ crc[7:0];
      b = b ^ {b[3:0], 4'b0000};
      return {b, crc[15:8]} ^ {12'b0, b[7:4]} ^ {5'b0, b, 3'b000};
   endfunction

endpackage

@@ sv/crcdf_parser.sv @@
module crcdf_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          in_byte,
   input  logic [7:0]          max_length,
   output crcdf_pkg::push_type push
);

   crcdf_pkg::parse_state_type state_ff, state_in;
   logic [7:0]  type_ff, type_in;
   logic [7:0]  length_ff, length_in;
   logic [7:0]  crc_low_ff, crc_low_in;
   logic [15:0] rx_crc_ff, rx_crc_in;
   logic [15:0] crc_ff, crc_in;
   logic [7:0]  count_ff, count_in;

   logic [15:0] crc_step_w;
   crcdf_pkg::result_type end_res_w;
   crcdf_pkg::result_type data_res_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= crcdf_pkg::ST_HUNT;
         type_ff    <= '0;
         length_ff  <= '0;
         crc_low_ff <= '0;
         rx_crc_ff  <= '0;
         crc_ff     <= crcdf_pkg::CRC_INIT;
         count_ff   <= '0;
      end else if (accept) begin
         state_ff   <= state_in;
         type_ff    <= type_in;
         length_ff  <= length_in;
         crc_low_ff <= crc_low_in;
         rx_crc_ff  <= rx_crc_in;
         crc_ff     <= crc_in;
         count_ff   <= count_in;
      end
   end

   assign crc_step_w = crcdf_pkg::crc_step(in_byte, crc_ff);

   always_comb begin
      state_in   = state_ff;
      type_in    = type_ff;
      length_in  = length_ff;
      crc_low_in = crc_low_ff;
      rx_crc_in  = rx_crc_ff;
      crc_in     = crc_ff;
      count_in   = count_ff;

      end_res_w                = '0;
      end_res_w.packet_type    = type_ff;
      end_res_w.payload_length = length_ff;
      end_res_w.last           = 1'b1;
      end_res_w.kind           = crcdf_pkg::KIND_REJECT;

      data_res_w                = '0;
      data_res_w.kind           = crcdf_pkg::KIND_PAYLOAD;
      data_res_w.packet_type    = type_ff;
      data_res_w.payload_length = length_ff;
      data_res_w.byte_index     = count_ff;
      data_res_w.data_byte      = in_byte;

      push = '0;

      case (state_ff)
         crcdf_pkg::ST_TYPE: begin
            type_in  = in_byte;
            crc_in   = crc_step_w;
            state_in = crcdf_pkg::ST_LEN;
         end
         crcdf_pkg::ST_LEN: begin
            if (in_byte <= max_length) begin
               length_in = in_byte;
               crc_in    = crc_step_w;
               count_in  = '0;
               state_in  = crcdf_pkg::ST_CRCLO;
            end else begin
               state_in = crcdf_pkg::ST_HUNT;
            end
         end
         crcdf_pkg::ST_CRCLO: begin
            crc_low_in = in_byte;
            state_in   = crcdf_pkg::ST_CRCHI;
         end
         crcdf_pkg::ST_CRCHI: begin
            rx_crc_in = {in_byte, crc_low_ff};
            if (length_ff == 8'd0) begin
               // empty payload: the packet ends on the crc high byte
               if (crc_ff == rx_crc_in) end_res_w.kind = crcdf_pkg::KIND_ACCEPT;
               push.count = 2'd1;
               push.first = end_res_w;
               count_in   = '0;
               state_in   = crcdf_pkg::ST_HUNT;
            end else begin
               state_in = crcdf_pkg::ST_DATA;
            end
         end
         crcdf_pkg::ST_DATA: begin
            crc_in   = crc_step_w;
            count_in = count_ff + 8'd1;
            if (count_in == length_ff) begin
               if (crc_step_w == rx_crc_ff) end_res_w.kind = crcdf_pkg::KIND_ACCEPT;
               push.count  = 2'd2;
               push.first  = data_res_w;
               push.second = end_res_w;
               count_in    = '0;
               state_in    = crcdf_pkg::ST_HUNT;
            end else begin
               data_res_w.last = 1'b1;
               push.count      = 2'd1;
               push.first      = data_res_w;
            end
         end
         default: begin
            state_in = crcdf_pkg::ST_HUNT;
            if (in_byte == crcdf_pkg::START_BYTE) begin
               crc_in   = crcdf_pkg::CRC_INIT;
               count_in = '0;
               state_in = crcdf_pkg::ST_TYPE;
            end
         end
      endcase

      if (!accept) push.count = 2'd0;
   end

endmodule

@@ sv/crcdf_result_queue.sv @@
module crcdf_result_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  crcdf_pkg::push_type   push,
   input  logic                  pop,
   output logic                  room,
   output logic                  head_valid,
   output crcdf_pkg::result_type head
);

   crcdf_pkg::result_type entries_ff [crcdf_pkg::QUEUE_DEPTH];

   logic [crcdf_pkg::PTR_W-1:0] head_ff, head_in;
   logic [crcdf_pkg::PTR_W-1:0] tail_ff, tail_in;
   logic [crcdf_pkg::PTR_W-1:0] tail_next_w;
   logic [crcdf_pkg::CNT_W-1:0] count_ff, count_in;

   assign tail_next_w = tail_ff + crcdf_pkg::PTR_W'(1);

   always_comb begin
      head_in  = head_ff + crcdf_pkg::PTR_W'(pop);
      tail_in  = tail_ff + crcdf_pkg::PTR_W'(push.count);
      count_in = count_ff + crcdf_pkg::CNT_W'(push.count) - crcdf_pkg::CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) entries_ff[tail_ff] <= push.first;
      if (push.count == 2'd2) entries_ff[tail_next_w] <= push.second;
   end

   // a beat may add two entries, so keep two free before taking it
   assign room       = count_ff <= crcdf_pkg::CNT_W'(crcdf_pkg::QUEUE_DEPTH - 2);
   assign head_valid = count_ff != '0;
   assign head       = entries_ff[head_ff];

endmodule

@@ sv/crc16_packet_deframer.sv @@
// results: each is written into the result queue as the byte causing it is taken
// throughput: one byte per cycle; the last payload byte of a packet yields two
// result beats, which the four-entry result queue absorbs, so the input stalls
// only while the result side stalls
// reset: synchronous, active high; clears the parser to hunting, the crc to all
// ones, empties the result queue and sets max_length to 200
module crc16_packet_deframer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_packet_type,
   output logic [7:0] rsp_payload_length,
   output logic [7:0] rsp_byte_index,
   output logic [7:0] rsp_data_byte,
   output logic       rsp_last,
   input  logic       csr_valid,
   output logic       csr_ready,
   input  logic [7:0] csr_data
);

   logic [7:0] max_length_ff;
   logic       accept_w;
   logic       room_w;
   crcdf_pkg::push_type   push_w;
   crcdf_pkg::result_type head_w;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_length_ff <= crcdf_pkg::MAX_LENGTH_RESET;
      end else if (csr_valid && csr_ready) begin
         max_length_ff <= csr_data;
      end
   end

   assign req_stall = !room_w;
   assign accept_w  = req_valid && !req_stall;

   crcdf_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept_w),
      .in_byte    (req_in_byte),
      .max_length (max_length_ff),
      .push       (push_w)
   );

   crcdf_result_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push_w),
      .pop        (rsp_valid && !rsp_stall),
      .room       (room_w),
      .head_valid (rsp_valid),
      .head       (head_w)
   );

   assign rsp_kind           = head_w.kind;
   assign rsp_packet_type    = head_w.packet_type;
   assign rsp_payload_length = head_w.payload_length;
   assign rsp_byte_index     = head_w.byte_index;
   assign rsp_data_byte      = head_w.data_byte;
   assign rsp_last           = head_w.last;

endmodule

@@ sv/crcdf_port_checker.sv @@
`include "crc16_packet_deframer_defines.svh"

module crcdf_port_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_kind,
   input logic [7:0] rsp_packet_type,
   input logic [7:0] rsp_payload_length,
   input logic [7:0] rsp_byte_index,
   input logic [7:0] rsp_data_byte,
   input logic       rsp_last
);

   logic end_beat_w;
   logic data_beat_w;
   logic end_shape_w;
   logic mid_beat_w;

   assign end_beat_w  = rsp_valid && (rsp_kind != crcdf_pkg::KIND_PAYLOAD);
   assign data_beat_w = rsp_valid && (rsp_kind == crcdf_pkg::KIND_PAYLOAD);
   assign end_shape_w = rsp_last && (rsp_byte_index == 8'd0) && (rsp_data_byte == 8'd0) &&
                        ((rsp_kind == crcdf_pkg::KIND_ACCEPT) ||
                         (rsp_kind == crcdf_pkg::KIND_REJECT));
   assign mid_beat_w  = rsp_valid && !rsp_stall && !rsp_last;

   // packet end beats close the packet and carry no byte
   `CRCDF_ASSERT(a_end_beat_shape, clock, reset, end_beat_w |-> end_shape_w, "malformed end beat")

   // payload positions stay inside the declared length
   `CRCDF_ASSERT(a_index_in_range, clock, reset,
      data_beat_w |-> (rsp_byte_index < rsp_payload_length), "payload index beyond length")

   // a payload beat without last is always followed by more of the same packet
   `CRCDF_ASSERT(a_packet_continues, clock, reset,
      mid_beat_w ##1 rsp_valid |-> (rsp_packet_type == $past(rsp_packet_type)) &&
         (rsp_payload_length == $past(rsp_payload_length)),
      "packet header changed mid packet")

   // nothing is offered straight after reset
   `CRCDF_ASSERT_ALWAYS(a_empty_after_reset, clock, $past(reset) |-> !rsp_valid,
      "result offered after reset")

   // a stalled result beat holds
   `CRCDF_ASSERT(a_rsp_hold, clock, reset,
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_kind) &&
         $stable(rsp_byte_index) && $stable(rsp_data_byte) && $stable(rsp_last)),
      "stalled result changed")

endmodule

bind crc16_packet_deframer crcdf_port_checker u_port_checker (.*);

@@ test/tb_top.sv @@
module tb_top;

   typedef logic [7:0] byte_queue [$];

   // shadow deframer: tracks the parser and queues the results each beat should cause
   class deframe_scoreboard;
      logic [7:0]                 max_len;
      crcdf_pkg::parse_state_type state;
      logic [7:0]                 held_type;
      logic [7:0]                 held_len;
      logic [7:0]                 crc_lo;
      logic [7:0]                 count;
      logic [15:0]                rx_crc;
      logic [15:0]                run_crc;
      crcdf_pkg::result_type      pending_q [$];
      int                         errors;

      function new();
         max_len   = crcdf_pkg::MAX_LENGTH_RESET;
         state     = crcdf_pkg::ST_HUNT;
         held_type = '0;
         held_len  = '0;
         crc_lo    = '0;
         count     = '0;
         rx_crc    = '0;
         run_crc   = crcdf_pkg::CRC_INIT;
         errors    = 0;
      endfunction

      // bitwise reflected form, polynomial 0x8408
      function logic [15:0] crc_update(logic [7:0] d, logic [15:0] c);
         logic [15:0] r;
         r = c ^ {8'h00, d};
         for (int i = 0; i < 8; i++)
            r = r[0] ? ((r >> 1) ^ 16'h8408) : (r >> 1);
         return r;
      endfunction

      function void push(logic [1:0] kind, logic [7:0] idx, logic [7:0] data, logic last);
         pending_q.push_back('{kind: kind, packet_type: held_type, payload_length: held_len,
                               byte_index: idx, data_byte: data, last: last});
      endfunction

      function void end_packet();
         push((run_crc == rx_crc) ? crcdf_pkg::KIND_ACCEPT : crcdf_pkg::KIND_REJECT,
              8'h00, 8'h00, 1'b1);
         state = crcdf_pkg::ST_HUNT;
         count = '0;
      endfunction

      function void note_byte(logic [7:0] b);
         case (state)
            crcdf_pkg::ST_TYPE: begin
               held_type = b;
               run_crc   = crc_update(b, run_crc);
               state     = crcdf_pkg::ST_LEN;
            end
            crcdf_pkg::ST_LEN: begin
               if (b <= max_len) begin
                  held_len = b;
                  run_crc  = crc_update(b, run_crc);
                  count    = '0;
                  state    = crcdf_pkg::ST_CRCLO;
               end else begin
                  state = crcdf_pkg::ST_HUNT;
               end
            end
            crcdf_pkg::ST_CRCLO: begin
               crc_lo = b;
               state  = crcdf_pkg::ST_CRCHI;
            end
            crcdf_pkg::ST_CRCHI: begin
               rx_crc = {b, crc_lo};
               if (held_len == 8'h00) end_packet();
               else state = crcdf_pkg::ST_DATA;
            end
            crcdf_pkg::ST_DATA: begin
               run_crc = crc_update(b, run_crc);
               push(crcdf_pkg::KIND_PAYLOAD, count, b, 8'(count + 1) != held_len);
               count = 8'(count + 1);
               if (count == held_len) end_packet();
            end
            default: begin
               // start bytes inside a packet never get here, so no resync
               state = crcdf_pkg::ST_HUNT;
               if (b == crcdf_pkg::START_BYTE) begin
                  run_crc = crcdf_pkg::CRC_INIT;
                  count   = '0;
                  state   = crcdf_pkg::ST_TYPE;
               end
            end
         endcase
      endfunction

      function void check_result(crcdf_pkg::result_type got);
         crcdf_pkg::result_type exp;
         if (pending_q.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("unexpected beat: kind %0d type %02h len %0d idx %0d data %02h last %0b",
                        got.kind, got.packet_type, got.payload_length, got.byte_index,
                        got.data_byte, got.last);
            return;
         end
         exp = pending_q.pop_front();
         if (got.kind !== exp.kind || got.packet_type !== exp.packet_type ||
             got.payload_length !== exp.payload_length || got.byte_index !== exp.byte_index ||
             got.data_byte !== exp.data_byte || got.last !== exp.last) begin
            errors++;
            if (errors <= 10) begin
               $display("mismatch: exp kind %0d type %02h len %0d idx %0d data %02h last %0b",
                        exp.kind, exp.packet_type, exp.payload_length, exp.byte_index,
                        exp.data_byte, exp.last);
               $display("          got kind %0d type %02h len %0d idx %0d data %02h last %0b",
                        got.kind, got.packet_type, got.payload_length, got.byte_index,
                        got.data_byte, got.last);
            end
         end
      endfunction
   endclass

   logic       clock;
   logic       reset;
   logic       req_valid;
   logic       req_stall;
   logic [7:0] req_in_byte;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [1:0] rsp_kind;
   logic [7:0] rsp_packet_type;
   logic [7:0] rsp_payload_length;
   logic [7:0] rsp_byte_index;
   logic [7:0] rsp_data_byte;
   logic       rsp_last;
   logic       csr_valid;
   logic       csr_ready;
   logic [7:0] csr_data;

   deframe_scoreboard     sb = new();
   crcdf_pkg::result_type seen;
   int                    idle_pct;
   int                    stall_pct;
   int                    items_sent;

   crc16_packet_deframer i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_in_byte        (req_in_byte),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_kind           (rsp_kind),
      .rsp_packet_type    (rsp_packet_type),
      .rsp_payload_length (rsp_payload_length),
      .rsp_byte_index     (rsp_byte_index),
      .rsp_data_byte      (rsp_data_byte),
      .rsp_last           (rsp_last),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_data           (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #2_000_000;
      $display("tb_top: errors");
      $finish;
   end

   // result side: check accepted beats, stall at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen = '{kind: rsp_kind, packet_type: rsp_packet_type,
                     payload_length: rsp_payload_length, byte_index: rsp_byte_index,
                     data_byte: rsp_data_byte, last: rsp_last};
            sb.check_result(seen);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   task automatic send_byte(logic [7:0] b);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_byte(b);
   endtask

   // keep below the payload size gives a packet cut short
   task automatic send_packet(logic [7:0] ptype, byte_queue pl, bit corrupt, int keep);
      logic [15:0] crc;
      crc = sb.crc_update(ptype, crcdf_pkg::CRC_INIT);
      crc = sb.crc_update(8'(pl.size()), crc);
      foreach (pl[i]) crc = sb.crc_update(pl[i], crc);
      if (corrupt) crc = crc ^ (16'h0001 << $urandom_range(15));
      send_byte(crcdf_pkg::START_BYTE);
      send_byte(ptype);
      send_byte(8'(pl.size()));
      send_byte(crc[7:0]);
      send_byte(crc[15:8]);
      for (int i = 0; i < keep; i++) send_byte(pl[i]);
      items_sent += 5 + keep;
   endtask

   function automatic byte_queue random_payload(int n);
      byte_queue q;
      for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(255)));
      return q;
   endfunction

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_max_length(logic [7:0] v);
      csr_valid <= 1'b1;
      csr_data  <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid  <= 1'b0;
      sb.max_len = v;
   endtask

   // mostly well-formed packets, the rest bad crc, noise, oversize headers, cut packets
   task automatic random_traffic(int target);
      int mark;
      int r;
      int len;
      int cap;
      int n;
      mark = items_sent;
      while (items_sent - mark < target) begin
         r   = $urandom_range(99);
         cap = (sb.max_len < 8) ? int'(sb.max_len) : 8;
         len = ($urandom_range(19) == 0) ? $urandom_range(sb.max_len) : $urandom_range(cap);
         if (r < 72) begin
            send_packet(8'($urandom_range(255)), random_payload(len), 1'b0, len);
         end else if (r < 84) begin
            send_packet(8'($urandom_range(255)), random_payload(len), 1'b1, len);
         end else if (r < 90) begin
            n = $urandom_range(1, 4);
            repeat (n) send_byte(8'($urandom_range(255)));
            items_sent += n;
         end else if (r < 95 && sb.max_len != 8'hFF) begin
            send_byte(crcdf_pkg::START_BYTE);
            send_byte(8'($urandom_range(255)));
            send_byte($urandom_range(1) ? 8'(sb.max_len + 1)
                                        : 8'($urandom_range(sb.max_len + 1, 255)));
            items_sent += 3;
         end else begin
            send_packet(8'($urandom_range(255)), random_payload(len), $urandom_range(1),
                        (len == 0) ? 0 : $urandom_range(len - 1));
         end
      end
   endtask

   initial begin
      byte_queue none;
      byte_queue fixed;
      int        phase_idle [4];
      int        phase_stall [4];
      logic [7:0] cfg;

      phase_idle  = '{0, 54, 0, 18};
      phase_stall = '{0, 0, 54, 18};
      reset       = 1'b1;
      req_valid   = 1'b0;
      req_in_byte = 8'h00;
      rsp_stall   = 1'b0;
      csr_valid   = 1'b0;
      csr_data    = 8'h00;
      idle_pct    = 0;
      stall_pct   = 0;
      items_sent  = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: noise while hunting, empty packets good and bad, oversize header,
      // start byte and extremes inside the payload
      send_byte(8'h00);
      send_byte(8'hFF);
      send_packet(8'hFF, none, 1'b0, 0);
      send_packet(8'h00, none, 1'b1, 0);
      send_byte(crcdf_pkg::START_BYTE);
      send_byte(8'h3C);
      send_byte(8'd201);
      fixed = {crcdf_pkg::START_BYTE, 8'h00, 8'hFF};
      send_packet(8'h07, fixed, 1'b0, 3);
      drain();

      for (int p = 0; p < 4; p++) begin
         case (p)
            0:       cfg = 8'hFF;
            1:       cfg = 8'h00;
            2:       cfg = 8'($urandom_range(1, 254));
            default: cfg = 8'd8;
         endcase
         write_max_length(cfg);
         idle_pct  = phase_idle[p];
         stall_pct = phase_stall[p];
         random_traffic(90);
         // longest packet reaches the top payload index
         if (p == 0) send_packet(8'h5A, random_payload(255), 1'b0, 255);
         drain();
      end

      if (sb.errors == 0 && sb.pending_q.size() == 0)
         $display("tb_top: clean");
      else
         $display("tb_top: errors");
      $finish;
   end

endmodule
